@@ rtl/emm_pkg.sv @@
// Shared types, codes and the CRC-16/Modbus byte update for the meter reply parser.
package emm_pkg;

  localparam int unsigned FrameLen     = 25;
  localparam int unsigned CrcBytes     = FrameLen - 2;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [7:0]  FuncCode     = 8'h04;
  localparam logic [7:0]  DataCount    = 8'h14;
  localparam logic [7:0]  DevAddrReset = 8'hF8;
  localparam int unsigned QueueDepthDefault = 2;

  // Input opcode codes as they arrive on the stream.
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SHORT  = 2'd1;
  localparam logic [1:0] ST_HEADER = 2'd2;
  localparam logic [1:0] ST_CRC    = 2'd3;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pf;
    logic [15:0] frequency;
    logic [31:0] energy;
    logic [31:0] power;
    logic [31:0] current;
    logic [15:0] voltage;
    logic [1:0]  status;
  } result_t;

  // One reflected CRC-16 byte update, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/emm_front.sv @@
// Front end: accepts input beats, decodes the opcode and drops unused codes.
module emm_front
  import emm_pkg::*;
(
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte[7:0]
  input  logic [1:0] in_tuser,   // opcode[1:0]
  output logic       push_valid,
  output cmd_t       push_cmd,
  input  logic       push_ready
);

  // Take a beat whenever the queue has room.
  assign in_tready = push_ready;

  // Decode the opcode; an unused code is accepted and dropped.
  always_comb begin
    push_cmd.data = in_tdata;
    push_cmd.kind = CMD_START;
    push_valid    = 1'b0;
    case (in_tuser)
      OP_START: begin
        push_cmd.kind = CMD_START;
        push_valid    = in_tvalid;
      end
      OP_BYTE: begin
        push_cmd.kind = CMD_BYTE;
        push_valid    = in_tvalid;
      end
      OP_TIMEOUT: begin
        push_cmd.kind = CMD_TIMEOUT;
        push_valid    = in_tvalid;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/emm_queue.sv @@
// Short command queue between the front end and the frame engine.
module emm_queue
  import emm_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDefault
)(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap and track the fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold the payload; no reset needed.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/emm_back.sv @@
// Frame engine: byte count, running CRC, header check, field capture and result register.
module emm_back
  import emm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic [7:0] dev_addr,
  input  logic    cmd_valid,
  output logic    cmd_ready,
  input  cmd_t    cmd,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic [4:0]  byte_count_r, byte_count_nxt;
  logic        collecting_r, collecting_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        header_good_r, header_good_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] voltage_r, voltage_nxt;
  logic [31:0] current_r, current_nxt;
  logic [31:0] power_r, power_nxt;
  logic [31:0] energy_r, energy_nxt;
  logic [15:0] frequency_r, frequency_nxt;
  logic [15:0] pf_r, pf_nxt;

  logic        res_valid_r, res_valid_nxt;
  result_t     res_r, res_nxt;
  logic        emit;
  logic        pop;
  logic [7:0]  b;
  logic [4:0]  i;

  // Take a command only when the result register is free or being emptied.
  assign cmd_ready = !res_valid_r || res_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign b         = cmd.data;
  assign i         = byte_count_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    collecting_nxt  = collecting_r;
    crc_nxt         = crc_r;
    header_good_nxt = header_good_r;
    crc_lo_nxt      = crc_lo_r;
    voltage_nxt     = voltage_r;
    current_nxt     = current_r;
    power_nxt       = power_r;
    energy_nxt      = energy_r;
    frequency_nxt   = frequency_r;
    pf_nxt          = pf_r;
    emit            = 1'b0;
    res_nxt         = '0;
    res_nxt.status  = ST_OK;

    if (pop) begin
      case (cmd.kind)
        CMD_START: begin
          // Drop any frame in progress and open a fresh one.
          collecting_nxt  = 1'b1;
          byte_count_nxt  = '0;
          crc_nxt         = CrcInit;
          header_good_nxt = 1'b1;
          crc_lo_nxt      = '0;
          voltage_nxt     = '0;
          current_nxt     = '0;
          power_nxt       = '0;
          energy_nxt      = '0;
          frequency_nxt   = '0;
          pf_nxt          = '0;
        end
        CMD_TIMEOUT: begin
          if (collecting_r) begin
            collecting_nxt = 1'b0;
            emit           = 1'b1;
            res_nxt.status = ST_SHORT;
          end
        end
        CMD_BYTE: begin
          if (collecting_r) begin
            if (i < 5'(CrcBytes)) begin
              crc_nxt = crc_byte(crc_r, b);
            end
            if ((i == 5'd0) && (b != dev_addr)) header_good_nxt = 1'b0;
            if ((i == 5'd1) && (b != FuncCode)) header_good_nxt = 1'b0;
            if ((i == 5'd2) && (b != DataCount)) header_good_nxt = 1'b0;

            // Shift the byte into the field that owns this position.
            if (i >= 5'd3 && i <= 5'd4) begin
              voltage_nxt = {voltage_r[7:0], b};
            end else if (i >= 5'd5 && i <= 5'd8) begin
              current_nxt = {current_r[23:0], b};
            end else if (i >= 5'd9 && i <= 5'd12) begin
              power_nxt = {power_r[23:0], b};
            end else if (i >= 5'd13 && i <= 5'd16) begin
              energy_nxt = {energy_r[23:0], b};
            end else if (i >= 5'd17 && i <= 5'd18) begin
              frequency_nxt = {frequency_r[7:0], b};
            end else if (i >= 5'd19 && i <= 5'd20) begin
              pf_nxt = {pf_r[7:0], b};
            end else if (i == 5'(CrcBytes)) begin
              crc_lo_nxt = b;
            end

            byte_count_nxt = i + 5'd1;

            // Judge the frame on its last byte: header first, then CRC.
            if (i == 5'(FrameLen - 1)) begin
              collecting_nxt = 1'b0;
              emit           = 1'b1;
              if (!header_good_r) begin
                res_nxt.status = ST_HEADER;
              end else if ({b, crc_lo_r} != crc_r) begin
                res_nxt.status = ST_CRC;
              end else begin
                res_nxt.status    = ST_OK;
                res_nxt.voltage   = voltage_r;
                res_nxt.current   = current_r;
                res_nxt.power     = power_r;
                res_nxt.energy    = energy_r;
                res_nxt.frequency = frequency_r;
                res_nxt.pf        = pf_r;
              end
            end
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    // Load a new result, or drop the one just taken.
    if (emit) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      collecting_r  <= 1'b0;
      crc_r         <= CrcInit;
      header_good_r <= 1'b1;
      crc_lo_r      <= '0;
      voltage_r     <= '0;
      current_r     <= '0;
      power_r       <= '0;
      energy_r      <= '0;
      frequency_r   <= '0;
      pf_r          <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      collecting_r  <= collecting_nxt;
      crc_r         <= crc_nxt;
      header_good_r <= header_good_nxt;
      crc_lo_r      <= crc_lo_nxt;
      voltage_r     <= voltage_nxt;
      current_r     <= current_nxt;
      power_r       <= power_nxt;
      energy_r      <= energy_nxt;
      frequency_r   <= frequency_nxt;
      pf_r          <= pf_nxt;
      res_valid_r   <= res_valid_nxt;
    end
  end

  // Hold the result payload until a new one is loaded.
  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ rtl/energy_meter_modbus_reply_parser_core.sv @@
// Top level of the meter reply parser: front end, command queue, frame engine, config register.
//
// Input stream: one beat per event. in_tuser carries the opcode (start of frame,
// received byte, receive timeout), in_tdata the received byte. A start opens a
// frame; 25 bytes later one result beat comes out with a status and the raw
// measurement fields. A timeout in an open frame gives a short-frame result.
// Output stream: one beat per finished frame, status in the low bits of out_tdata,
// then voltage, current, power, energy, frequency and power factor; a failed
// frame carries zeros in all measurement fields.
// Throughput: one input beat per cycle, sustained while the output is taken.
// Order: a closing beat is written into the command queue, then popped by the frame
// engine, which loads the result register that drives out_tvalid.
// When the receiver stalls, the result register holds, the frame engine stops,
// and the command queue absorbs up to QUEUE_DEPTH beats before in_tready drops.
// cfg_data sets the expected slave address; write it only while the block is idle.
// Reset (rst_n low, synchronous) empties the queue, closes any frame and sets the
// address back to 0xF8.
module energy_meter_modbus_reply_parser_core
  import emm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
)(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // rx_byte[7:0]
  input  logic [7:0]   in_tuser,    // opcode[1:0], zero fill above
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,   // status[1:0], voltage_raw[17:2], current_raw[49:18],
                                    // power_raw[81:50], energy_raw[113:82],
                                    // frequency_raw[129:114], power_factor_raw[145:130], zeros
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data     // device_address[7:0]
);

  logic    [7:0] dev_addr_r, dev_addr_nxt;
  logic          push_valid, push_ready;
  cmd_t          push_cmd;
  logic          q_valid, q_ready;
  cmd_t          q_cmd;
  result_t       res;

  // Accept config writes at any time.
  assign cfg_ready = 1'b1;

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    if (cfg_valid && cfg_ready) begin
      dev_addr_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DevAddrReset;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  emm_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser[1:0]),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  emm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  emm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_addr  (dev_addr_r),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result, first field lowest.
  assign out_tdata = {6'b0, res.pf, res.frequency, res.energy, res.power,
                      res.current, res.voltage, res.status};

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the meter reply parser: frame stimulus, prediction and result checks.
module testbench;
  import emm_pkg::*;

  // Opcode value that has no meaning on the stream and must be ignored.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef enum {
    FR_GOOD, FR_BAD_ADDR, FR_BAD_FUNC, FR_BAD_COUNT, FR_BAD_CRC, FR_SHORT, FR_RESTART
  } frame_kind_t;

  typedef enum {PAT_RANDOM, PAT_ZERO, PAT_ONES} payload_pat_t;

  // Predicts reply results from accepted beats and checks the beats that come out.
  class modbus_scoreboard;
    logic [7:0]  dev_addr;
    logic [4:0]  nbytes;
    bit          open;
    logic [15:0] crc;
    bit          hdr_ok;
    logic [7:0]  crc_lo;
    result_t     acc;
    result_t     reply_q[$];
    int          mismatches;

    function new();
      dev_addr = DevAddrReset;
      open = 0;
      mismatches = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      repeat (8) begin
        c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
    endfunction

    function void clear_frame();
      nbytes = '0;
      crc = CrcInit;
      hdr_ok = 1;
      crc_lo = '0;
      acc = '0;
    endfunction

    function void set_address(logic [7:0] v);
      dev_addr = v;
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] b);
      result_t r;
      int i;
      r = '0;
      case (op)
        OP_START: begin
          clear_frame();
          open = 1;
        end
        OP_TIMEOUT: begin
          if (open) begin
            open = 0;
            r.status = ST_SHORT;
            reply_q.push_back(r);
          end
        end
        OP_BYTE: begin
          if (open) begin
            i = nbytes;
            if (i < CrcBytes) crc = crc_step(crc, b);
            // Header bytes: address, function code, byte count
            if (i == 0 && b != dev_addr) hdr_ok = 0;
            if (i == 1 && b != FuncCode) hdr_ok = 0;
            if (i == 2 && b != DataCount) hdr_ok = 0;
            // Shift measurement bytes in big-endian
            if (i >= 3 && i <= 4) acc.voltage = {acc.voltage[7:0], b};
            else if (i >= 5 && i <= 8) acc.current = {acc.current[23:0], b};
            else if (i >= 9 && i <= 12) acc.power = {acc.power[23:0], b};
            else if (i >= 13 && i <= 16) acc.energy = {acc.energy[23:0], b};
            else if (i >= 17 && i <= 18) acc.frequency = {acc.frequency[7:0], b};
            else if (i >= 19 && i <= 20) acc.pf = {acc.pf[7:0], b};
            else if (i == FrameLen - 2) crc_lo = b;
            nbytes = 5'(i + 1);
            // Judge the frame on its last byte
            if (i == FrameLen - 1) begin
              open = 0;
              if (!hdr_ok) begin
                r.status = ST_HEADER;
              end else if ({b, crc_lo} != crc) begin
                r.status = ST_CRC;
              end else begin
                r = acc;
                r.status = ST_OK;
              end
              reply_q.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      if (mismatches < 10) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endfunction

    function void field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) report($sformatf("%s expected %h, got %h", name, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (reply_q.size() == 0) begin
        report($sformatf("result beat with none pending, status %0d", got.status));
        return;
      end
      want = reply_q.pop_front();
      field("status", want.status, got.status);
      field("voltage", want.voltage, got.voltage);
      field("current", want.current, got.current);
      field("power", want.power, got.power);
      field("energy", want.energy, got.energy);
      field("frequency", want.frequency, got.frequency);
      field("power_factor", want.pf, got.pf);
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic [7:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_data;

  modbus_scoreboard sb = new();
  int items_sent = 0;
  int in_burst = 0;
  int out_burst = 0;

  energy_meter_modbus_reply_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Check every result beat taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(result_t'(out_tdata[$bits(result_t)-1:0]));
    end
  end

  // Receiver: random stalls per beat, with occasional stretches of none
  initial begin
    int stall;
    out_tready = 0;
    @(negedge clk);
    forever begin
      if (out_burst > 0) begin
        stall = 0;
        out_burst--;
      end else begin
        stall = $urandom_range(0, 3);
        if ($urandom_range(0, 31) == 0) out_burst = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_tready = 0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1;
      do @(posedge clk); while (!(out_tvalid === 1'b1));
      @(negedge clk);
    end
  end

  // Send one beat after a random gap; returns at the falling edge after acceptance
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    int gap;
    if (in_burst > 0) begin
      gap = 0;
      in_burst--;
    end else begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 63) == 0) in_burst = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = {6'b0, op};
    in_tdata = b;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, b);
    items_sent++;
    @(negedge clk);
  endtask

  // Write the expected slave address while the block is idle
  task automatic write_address(logic [7:0] v);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_address(v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Wait until every pending result is out, then let the pipeline settle
  task automatic drain();
    int n;
    in_tvalid = 0;
    n = 0;
    while (sb.pending() > 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
    repeat (8) @(negedge clk);
  endtask

  // Build and send one reply frame of the given kind
  task automatic send_frame(frame_kind_t kind, payload_pat_t pat);
    logic [7:0] fb [FrameLen];
    logic [15:0] c;
    int cut;
    fb[0] = sb.dev_addr;
    fb[1] = FuncCode;
    fb[2] = DataCount;
    for (int k = 3; k < CrcBytes; k++) begin
      case (pat)
        PAT_ZERO: fb[k] = 8'h00;
        PAT_ONES: fb[k] = 8'hFF;
        default:  fb[k] = 8'($urandom);
      endcase
    end
    // Corrupt the header before the CRC so the CRC still matches the corrupted bytes
    case (kind)
      FR_BAD_ADDR:  fb[0] ^= 8'($urandom_range(1, 255));
      FR_BAD_FUNC:  fb[1] ^= 8'($urandom_range(1, 255));
      FR_BAD_COUNT: fb[2] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    c = CrcInit;
    for (int k = 0; k < CrcBytes; k++) c = modbus_scoreboard::crc_step(c, fb[k]);
    fb[FrameLen-2] = c[7:0];
    fb[FrameLen-1] = c[15:8];
    // Break the CRC on its own, or together with a bad header
    if (kind == FR_BAD_CRC ||
        (kind inside {FR_BAD_ADDR, FR_BAD_FUNC, FR_BAD_COUNT} && $urandom_range(0, 1))) begin
      fb[FrameLen-2+$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    end
    cut = (kind == FR_SHORT || kind == FR_RESTART) ? $urandom_range(0, FrameLen-1) : FrameLen;
    send_item(OP_START, 8'($urandom));
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(0, 49) == 0) send_item(OP_RESERVED, 8'($urandom));
      send_item(OP_BYTE, fb[k]);
    end
    if (kind == FR_SHORT) send_item(OP_TIMEOUT, 8'($urandom));
  endtask

  // Mostly well-formed frames, the rest broken frames and noise
  task automatic run_random(int target);
    int r;
    payload_pat_t pat;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      pat = ($urandom_range(0, 9) == 0) ? PAT_ZERO :
            ($urandom_range(0, 9) == 0) ? PAT_ONES : PAT_RANDOM;
      if (r < 55) begin
        send_frame(FR_GOOD, pat);
        // Trailing bytes after a complete frame are dropped
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'($urandom));
        end
      end else if (r < 62) send_frame(FR_BAD_ADDR, pat);
      else if (r < 67) send_frame(FR_BAD_FUNC, pat);
      else if (r < 72) send_frame(FR_BAD_COUNT, pat);
      else if (r < 80) send_frame(FR_BAD_CRC, pat);
      else if (r < 88) send_frame(FR_SHORT, pat);
      else if (r < 93) send_frame(FR_RESTART, pat);
      else begin
        repeat ($urandom_range(1, 10)) send_item(2'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] addr_set [5];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 0;
    cfg_data = '0;
    addr_set = '{DevAddrReset, 8'h00, 8'hFF, 8'($urandom), DevAddrReset};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Idle-state beats that must be ignored, then short, restart and a full frame
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TIMEOUT, 8'hFF);
    send_item(OP_RESERVED, 8'hFF);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, DevAddrReset);
    send_item(OP_BYTE, FuncCode);
    send_item(OP_TIMEOUT, 8'h00);
    send_item(OP_START, 8'hFF);
    send_frame(FR_GOOD, PAT_ONES);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_TIMEOUT, 8'h00);

    // Random phases; from the second on, each first drains and writes the next address from addr_set
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        write_address(addr_set[ph]);
      end
      run_random(items_sent + 380);
      send_item(OP_TIMEOUT, 8'($urandom));
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
